>>> rtl/sme_pkg.sv
// Package: shared types, constants and opcode/fault codes for the stack machine executor
`timescale 1ns / 1ps
package sme_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned PC_BITS_DEF     = 16;
  localparam int unsigned OP_W            = 5;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned PLEN_W          = 16;
  localparam int unsigned FAULT_W         = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT = 5'd0,  OP_STORE = 5'd1,  OP_LOAD  = 5'd2,  OP_PUSH = 5'd3,
    OP_JUMPZ = 5'd4,  OP_JUMP  = 5'd5,  OP_HALT  = 5'd6,  OP_ADD  = 5'd7,
    OP_SUB   = 5'd8,  OP_MUL   = 5'd9,  OP_DIV   = 5'd10, OP_GT   = 5'd11,
    OP_GE    = 5'd12, OP_LT    = 5'd13, OP_LE    = 5'd14, OP_EQ   = 5'd15,
    OP_NE    = 5'd16, OP_AND   = 5'd17, OP_OR    = 5'd18, OP_NEG  = 5'd19,
    OP_NOT   = 5'd20
  } sme_op_t;

  localparam logic [OP_W-1:0] OP_LAST = 5'd20;

  typedef enum logic [FAULT_W-1:0] {
    FLT_NONE = 3'd0, FLT_UNDER = 3'd1, FLT_OVER = 3'd2, FLT_ADDR_NEG = 3'd3,
    FLT_ADDR_BIG = 3'd4, FLT_PROG = 3'd5, FLT_OPCODE = 3'd6, FLT_DIV0 = 3'd7
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_EXEC, ST_LOAD, ST_DIV, ST_WRITE, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch input word, run decode checks
    logic rd_a;      // read top of stack
    logic rd_b;      // read second entry
    logic exec;      // evaluate op, register result and faults
    logic rd_mem;    // load: read addressed word
    logic div_start;
    logic commit;    // write back and update architectural state
  } sme_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic run;       // not halted/faulted and pre-checks passed
    logic need_a;
    logic need_b;
    logic is_load;
    logic is_div;
    logic div_done;
    logic exec_ok;
  } sme_stat_t;

  function automatic logic [1:0] pop_count(input logic [OP_W-1:0] op);
    logic [1:0] n;
    case (op)
      OP_PRINT, OP_LOAD, OP_JUMPZ, OP_NEG, OP_NOT: n = 2'd1;
      OP_PUSH, OP_JUMP, OP_HALT: n = 2'd0;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  function automatic logic push_count(input logic [OP_W-1:0] op);
    logic p;
    case (op)
      OP_PRINT, OP_STORE, OP_JUMPZ, OP_JUMP, OP_HALT: p = 1'b0;
      default: p = 1'b1;
    endcase
    return p;
  endfunction

endpackage

>>> rtl/sme_if.sv
// Interfaces: valid/ready channels for instructions, results and configuration
`timescale 1ns / 1ps
interface sme_in_if;
  logic                            valid;
  logic                            ready;
  logic [sme_pkg::OP_W-1:0]        opcode;
  logic signed [sme_pkg::DATA_W-1:0] immediate;
  modport source (output valid, opcode, immediate, input ready);
  modport sink   (input valid, opcode, immediate, output ready);
endinterface

interface sme_out_if #(parameter int unsigned PC_BITS = sme_pkg::PC_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic [PC_BITS-1:0]                next_pc;
  logic                              print_valid;
  logic signed [sme_pkg::DATA_W-1:0] print_value;
  logic                              halted;
  logic [sme_pkg::FAULT_W-1:0]       fault_code;
  modport source (output valid, next_pc, print_valid, print_value, halted, fault_code,
                  input ready);
  modport sink   (input valid, next_pc, print_valid, print_value, halted, fault_code,
                  output ready);
endinterface

interface sme_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sme_pkg::PLEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/sme_divider.sv
// Radix-2 restoring divider for signed 32-bit words, one quotient bit per cycle
`timescale 1ns / 1ps
module sme_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sme_pkg::DATA_W-1:0]    dividend,
  input  logic [sme_pkg::DATA_W-1:0]    divisor,
  output logic                          done,
  output logic [sme_pkg::DATA_W-1:0]    quotient
);
  localparam int unsigned W  = sme_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, q_r[W-1]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      q_nxt    = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      den_nxt  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
      rem_nxt  = '0;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~q_r + 1'b1) : q_r;
endmodule

>>> rtl/sme_datapath.sv
// Datapath: architectural state, stack memory, checks, ALU and result register
`timescale 1ns / 1ps
module sme_datapath #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PC_BITS     = sme_pkg::PC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sme_pkg::sme_cmd_t           cmd,
  output sme_pkg::sme_stat_t          stat,
  input  logic [sme_pkg::OP_W-1:0]    in_opcode,
  input  logic [sme_pkg::DATA_W-1:0]  in_immediate,
  input  logic                        cfg_we,
  input  logic [sme_pkg::PLEN_W-1:0]  cfg_data,
  output logic [PC_BITS-1:0]          next_pc,
  output logic                        print_valid,
  output logic [sme_pkg::DATA_W-1:0]  print_value,
  output logic                        halted,
  output logic [sme_pkg::FAULT_W-1:0] fault_code
);
  localparam int unsigned W   = sme_pkg::DATA_W;
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned XW  = (PC_BITS > sme_pkg::PLEN_W ? PC_BITS : sme_pkg::PLEN_W) + 1;
  localparam int unsigned TW  = (CW > W ? CW : W) + 1;

  // architectural state
  logic [PC_BITS-1:0]          pc_r, pc_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic                        halt_r, halt_nxt;
  logic [sme_pkg::FAULT_W-1:0] flt_r, flt_nxt;
  logic [sme_pkg::PLEN_W-1:0]  plen_r;

  // per-item registers
  logic [sme_pkg::OP_W-1:0]    op_r;
  logic [W-1:0]                imm_r;
  logic [W-1:0]                a_r, b_r, res_r;
  logic                        run_r;
  logic [sme_pkg::FAULT_W-1:0] xflt_r;
  logic [PC_BITS-1:0]          xpc_r;
  logic                        wr_en_r;
  logic [AW-1:0]               wr_addr_r;
  logic                        pv_r;
  logic [sme_pkg::DATA_W-1:0]  pval_r;
  logic                        xhalt_r;
  logic [CW-1:0]               xcnt_r;

  logic [W-1:0] mem [STACK_DEPTH];
  logic [W-1:0] rd_q;
  logic [AW-1:0] rd_addr;

  // decode
  logic [1:0]   pops;
  logic         pushes;
  logic         op_known;
  logic         has_imm;
  logic [sme_pkg::FAULT_W-1:0] pre_flt;
  logic [XW-1:0] pc_x, pl_x;
  logic [TW-1:0] after;

  always_comb begin
    pops     = sme_pkg::pop_count(in_opcode);
    pushes   = sme_pkg::push_count(in_opcode);
    op_known = (in_opcode <= sme_pkg::OP_LAST);
    has_imm  = (in_opcode inside {sme_pkg::OP_PUSH, sme_pkg::OP_JUMPZ, sme_pkg::OP_JUMP});
    pc_x     = XW'(pc_r);
    pl_x     = XW'(plen_r);
    after    = TW'(cnt_r) - TW'(pops) + TW'(pushes);
    pre_flt  = sme_pkg::FLT_NONE;
    if (pc_x >= pl_x)                              pre_flt = sme_pkg::FLT_PROG;
    else if (!op_known)                            pre_flt = sme_pkg::FLT_OPCODE;
    else if (has_imm && (pc_x + 1'b1 >= pl_x))     pre_flt = sme_pkg::FLT_PROG;
    else if (TW'(cnt_r) < TW'(pops))               pre_flt = sme_pkg::FLT_UNDER;
    else if (after > TW'(STACK_DEPTH))             pre_flt = sme_pkg::FLT_OVER;
  end

  // memory read address
  always_comb begin
    rd_addr = AW'(cnt_r - 1'b1);
    if (cmd.rd_b)   rd_addr = AW'(cnt_r - CW'(2));
    if (cmd.rd_mem) rd_addr = a_r[AW-1:0];
  end

  // operands land straight in a_r / b_r; load data goes through rd_q
  always_ff @(posedge clk) begin
    if (cmd.rd_a)   a_r  <= mem[rd_addr];
    if (cmd.rd_b)   b_r  <= mem[rd_addr];
    if (cmd.rd_mem) rd_q <= mem[rd_addr];
    if (cmd.commit && run_r && xflt_r == sme_pkg::FLT_NONE && wr_en_r)
      mem[wr_addr_r] <= res_r;
  end

  // divider
  logic         div_done;
  logic [W-1:0] div_q;
  sme_divider u_div (
    .clk, .rst_n, .start(cmd.div_start), .dividend(b_r), .divisor(a_r),
    .done(div_done), .quotient(div_q)
  );

  // load data valid in rd_q
  logic got_m_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      got_m_r <= 1'b0;
    end else begin
      got_m_r <= cmd.rd_mem;
    end
  end

  // execute
  logic [sme_pkg::FAULT_W-1:0] e_flt;
  logic [W-1:0]                e_res;
  logic [PC_BITS-1:0]          e_pc;
  logic                        e_wr;
  logic [AW-1:0]               e_waddr;
  logic [CW-1:0]               e_cnt;
  logic                        e_pv, e_halt;
  logic [W-1:0]                a_v, b_v;
  logic signed [W-1:0]         sa, sb;
  logic                        tgt_bad;
  logic [PC_BITS-1:0]          pc1, pc2;

  function automatic logic [sme_pkg::FAULT_W-1:0] addr_flt(input logic [W-1:0] ad);
    logic [sme_pkg::FAULT_W-1:0] f;
    f = sme_pkg::FLT_NONE;
    if (ad[W-1])                                    f = sme_pkg::FLT_ADDR_NEG;
    else if ({1'b0, ad} >= (W+1)'(STACK_DEPTH))     f = sme_pkg::FLT_ADDR_BIG;
    return f;
  endfunction

  always_comb begin
    a_v = a_r; b_v = b_r;
    sa = $signed(a_v); sb = $signed(b_v);
    pc1 = pc_r + PC_BITS'(1);
    pc2 = pc_r + PC_BITS'(2);
    tgt_bad = imm_r[W-1] || ({1'b0, imm_r} >= (W+1)'(plen_r));
    e_flt = sme_pkg::FLT_NONE;
    e_res = '0;
    e_pc  = pc1;
    e_wr  = 1'b0;
    e_waddr = AW'(cnt_r - 1'b1);
    e_cnt = cnt_r;
    e_pv  = 1'b0;
    e_halt = 1'b0;
    case (op_r)
      sme_pkg::OP_PRINT: begin
        e_pv = 1'b1; e_res = a_v; e_cnt = cnt_r - 1'b1;
      end
      sme_pkg::OP_STORE: begin
        e_flt = addr_flt(b_v);
        e_wr = 1'b1; e_waddr = b_v[AW-1:0]; e_res = a_v; e_cnt = cnt_r - CW'(2);
      end
      sme_pkg::OP_LOAD: begin
        e_flt = addr_flt(a_v);
        e_wr = 1'b1;
      end
      sme_pkg::OP_PUSH: begin
        e_res = imm_r; e_wr = 1'b1; e_waddr = AW'(cnt_r); e_cnt = cnt_r + 1'b1; e_pc = pc2;
      end
      sme_pkg::OP_JUMPZ: begin
        e_cnt = cnt_r - 1'b1;
        if (a_v == '0) begin
          if (tgt_bad) e_flt = sme_pkg::FLT_PROG;
          e_pc = PC_BITS'(imm_r);
        end else begin
          e_pc = pc2;
        end
      end
      sme_pkg::OP_JUMP: begin
        if (tgt_bad) e_flt = sme_pkg::FLT_PROG;
        e_pc = PC_BITS'(imm_r);
      end
      sme_pkg::OP_HALT: begin
        e_halt = 1'b1; e_pc = pc_r;
      end
      default: begin
        e_wr = 1'b1;
        e_waddr = AW'(cnt_r - CW'(op_r inside {sme_pkg::OP_NEG, sme_pkg::OP_NOT} ? 1 : 2));
        e_cnt = cnt_r + 1'b1 - CW'(op_r inside {sme_pkg::OP_NEG, sme_pkg::OP_NOT} ? 1 : 2);
        case (op_r)
          sme_pkg::OP_ADD: e_res = b_v + a_v;
          sme_pkg::OP_SUB: e_res = b_v - a_v;
          sme_pkg::OP_MUL: e_res = b_v * a_v;
          sme_pkg::OP_DIV: if (a_v == '0) e_flt = sme_pkg::FLT_DIV0;
          sme_pkg::OP_GT:  e_res = W'(sb >  sa);
          sme_pkg::OP_GE:  e_res = W'(sb >= sa);
          sme_pkg::OP_LT:  e_res = W'(sb <  sa);
          sme_pkg::OP_LE:  e_res = W'(sb <= sa);
          sme_pkg::OP_EQ:  e_res = W'(b_v == a_v);
          sme_pkg::OP_NE:  e_res = W'(b_v != a_v);
          sme_pkg::OP_AND: e_res = W'((b_v != '0) && (a_v != '0));
          sme_pkg::OP_OR:  e_res = W'((b_v != '0) || (a_v != '0));
          sme_pkg::OP_NEG: e_res = '0 - a_v;
          default:         e_res = W'(a_v == '0);
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r   <= in_opcode;
      imm_r  <= in_immediate;
      xflt_r <= pre_flt;
    end
    if (got_m_r) res_r <= rd_q;
    if (cmd.exec) begin
      xflt_r    <= e_flt;
      xpc_r     <= e_pc;
      wr_en_r   <= e_wr;
      wr_addr_r <= e_waddr;
      xcnt_r    <= e_cnt;
      xhalt_r   <= e_halt;
      pv_r      <= e_pv;
      pval_r    <= e_res;
      if (op_r != sme_pkg::OP_LOAD) res_r <= e_res;
    end
    if (div_done) res_r <= div_q;
  end

  always_comb begin
    pc_nxt = pc_r; cnt_nxt = cnt_r; halt_nxt = halt_r; flt_nxt = flt_r;
    if (cmd.commit && run_r) begin
      if (xflt_r != sme_pkg::FLT_NONE) flt_nxt = xflt_r;
      else begin
        pc_nxt = xpc_r; cnt_nxt = xcnt_r; halt_nxt = xhalt_r;
      end
    end
  end

  logic pv_out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0; cnt_r <= '0; halt_r <= 1'b0; flt_r <= sme_pkg::FLT_NONE;
      plen_r <= sme_pkg::PLEN_W'(65535); run_r <= 1'b0; pv_out_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt; cnt_r <= cnt_nxt; halt_r <= halt_nxt; flt_r <= flt_nxt;
      if (cfg_we) plen_r <= cfg_data;
      if (cmd.start) begin
        run_r    <= !halt_r && flt_r == sme_pkg::FLT_NONE;
        pv_out_r <= 1'b0;
      end
      if (cmd.commit)
        pv_out_r <= run_r && xflt_r == sme_pkg::FLT_NONE && pv_r;
    end
  end

  always_comb begin
    stat.run      = run_r && xflt_r == sme_pkg::FLT_NONE;
    stat.need_a   = sme_pkg::pop_count(op_r) != 2'd0;
    stat.need_b   = sme_pkg::pop_count(op_r) == 2'd2;
    stat.is_load  = op_r == sme_pkg::OP_LOAD;
    stat.is_div   = op_r == sme_pkg::OP_DIV;
    stat.div_done = div_done;
    stat.exec_ok  = e_flt == sme_pkg::FLT_NONE;
  end

  assign next_pc     = pc_r;
  assign print_valid = pv_out_r;
  assign print_value = pv_out_r ? pval_r : '0;
  assign halted      = halt_r;
  assign fault_code  = flt_r;
endmodule

>>> rtl/sme_controller.sv
// Controller: sequences reads, execute, load/divide and write-back for one instruction
`timescale 1ns / 1ps
module sme_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sme_pkg::sme_stat_t stat,
  output sme_pkg::sme_cmd_t  cmd
);
  sme_pkg::state_t st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sme_pkg::ST_IDLE:  if (in_valid) st_nxt = sme_pkg::ST_RD_A;
      sme_pkg::ST_RD_A:
        if (!stat.run)        st_nxt = sme_pkg::ST_WRITE;
        else if (stat.need_b) st_nxt = sme_pkg::ST_RD_B;
        else                  st_nxt = sme_pkg::ST_EXEC;
      sme_pkg::ST_RD_B:  st_nxt = sme_pkg::ST_EXEC;
      sme_pkg::ST_EXEC:
        if (stat.exec_ok && stat.is_load)     st_nxt = sme_pkg::ST_LOAD;
        else if (stat.exec_ok && stat.is_div) st_nxt = sme_pkg::ST_DIV;
        else                                  st_nxt = sme_pkg::ST_WRITE;
      sme_pkg::ST_LOAD:  st_nxt = sme_pkg::ST_WRITE;
      sme_pkg::ST_DIV:   if (stat.div_done) st_nxt = sme_pkg::ST_WRITE;
      sme_pkg::ST_WRITE: st_nxt = sme_pkg::ST_OUT;
      sme_pkg::ST_OUT:   if (out_ready) st_nxt = in_valid ? sme_pkg::ST_RD_A : sme_pkg::ST_IDLE;
      default:           st_nxt = sme_pkg::ST_IDLE;
    endcase
  end

  // a word waiting in ST_OUT may be taken while the next one is accepted
  always_comb begin
    cmd = '0;
    in_ready  = (st_r == sme_pkg::ST_IDLE) || (st_r == sme_pkg::ST_OUT && out_ready);
    out_valid = (st_r == sme_pkg::ST_OUT);
    cmd.start = in_ready && in_valid;
    case (st_r)
      sme_pkg::ST_RD_A:  cmd.rd_a = stat.run && stat.need_a;
      sme_pkg::ST_RD_B:  cmd.rd_b = 1'b1;
      sme_pkg::ST_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.rd_mem    = stat.exec_ok && stat.is_load;
        cmd.div_start = stat.exec_ok && stat.is_div;
      end
      sme_pkg::ST_WRITE: cmd.commit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= sme_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end
endmodule

>>> rtl/stack_machine_executor_core.sv
// Top level: stack machine executor core, controller plus datapath
`timescale 1ns / 1ps
// Runs one stack-machine instruction per input word and returns one result word with the
// next fetch address, any printed value, halt flag and sticky fault code. Each word goes
// through one stack memory port: read top, read second, execute, optional load read or
// divide on the bit-serial divider, then write back; words that are ignored or fail their
// pre-checks go straight to write back. The result is offered after write back, and the
// next word is taken in the cycle the result goes out at the earliest. The stack is not
// cleared at reset; loads of words never written read undefined data. The user must write
// program_length through the cfg channel only while the block is idle; the block itself
// does not enforce this.
module stack_machine_executor_core #(
  parameter int unsigned STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PC_BITS     = sme_pkg::PC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  sme_in_if.sink   in_ch,
  sme_out_if.source out_ch,
  sme_cfg_if.sink  cfg_ch
);
  sme_pkg::sme_cmd_t  cmd;
  sme_pkg::sme_stat_t stat;

  // config always accepted; idle-only writes are the user's duty
  assign cfg_ch.ready = 1'b1;

  sme_controller u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  sme_datapath #(.STACK_DEPTH(STACK_DEPTH), .PC_BITS(PC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_opcode(in_ch.opcode), .in_immediate(in_ch.immediate),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .next_pc(out_ch.next_pc), .print_valid(out_ch.print_valid),
    .print_value(out_ch.print_value), .halted(out_ch.halted),
    .fault_code(out_ch.fault_code)
  );
endmodule
